>>> rtl/core/mtrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtrm_pkg;

   localparam int DIM_DEFAULT       = 4;
   localparam int NUM_TILES_DEFAULT = 8;

   localparam int FUNC_W  = 2;
   localparam int REG_W   = 3;
   localparam int POS_W   = 4;
   localparam int WORD_W  = 32;
   localparam int GROUP_W = 3;
   localparam int CSR_W   = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_ZERO  = 2'd2,
      FUNC_MAC   = 2'd3
   } func_type;

   localparam logic [CSR_W-1:0] CSR_M_GROUP = 2'd0;
   localparam logic [CSR_W-1:0] CSR_N_GROUP = 2'd1;

   localparam logic [WORD_W-1:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [WORD_W-1:0] FP_QUIET_BIT   = 32'h0040_0000;

   typedef enum logic {
      FPU_MUL = 1'b0,
      FPU_ADD = 1'b1
   } fpu_op_type;

   typedef struct packed {
      logic              start;
      fpu_op_type        op;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
   } fpu_rsp_type;

   // position of the leading one, counted from the top of a 48-bit word
   function automatic logic [5:0] lead_zeros48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) n = 6'(47 - i);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/mtrm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mtrm_req_if;
   logic                          valid;
   logic                          ready;
   logic [mtrm_pkg::FUNC_W-1:0]   func;
   logic [mtrm_pkg::REG_W-1:0]    dest_reg;
   logic [mtrm_pkg::REG_W-1:0]    src_a_reg;
   logic [mtrm_pkg::REG_W-1:0]    src_b_reg;
   logic [mtrm_pkg::POS_W-1:0]    panel_row;
   logic [mtrm_pkg::POS_W-1:0]    panel_col;
   logic [mtrm_pkg::WORD_W-1:0]   elem_in;
   modport source (output valid, func, dest_reg, src_a_reg, src_b_reg, panel_row,
                   panel_col, elem_in, input ready);
   modport sink   (input valid, func, dest_reg, src_a_reg, src_b_reg, panel_row,
                   panel_col, elem_in, output ready);
endinterface

interface mtrm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mtrm_pkg::WORD_W-1:0]   elem_out;
   logic                          status;
   modport source (output valid, elem_out, status, input ready);
   modport sink   (input valid, elem_out, status, output ready);
endinterface

interface mtrm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mtrm_pkg::CSR_W-1:0]    addr;
   logic [mtrm_pkg::GROUP_W-1:0]  wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mtrm_fpu.sv
`timescale 1ns / 1ps
`default_nettype none

module mtrm_fpu (
   input  logic                  clock,
   input  logic                  reset,
   input  mtrm_pkg::fpu_req_type fpu_req,
   output mtrm_pkg::fpu_rsp_type fpu_rsp
);
   import mtrm_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_LZC, F_ALIGN, F_ROUND} fstate_type;

   fstate_type         state_ff;
   logic               sign_ff;
   logic signed [10:0] exp_ff;
   logic [47:0]        man_ff;
   logic               bypass_ff;
   logic [31:0]        bval_ff;
   logic [5:0]         lz_ff;
   logic [7:0]         expf_ff;
   logic [22:0]        frac_ff;
   logic               guard_ff;
   logic               sticky_ff;
   logic               ovf_ff;
   logic [31:0]        result_ff;
   logic               done_ff;

   // front end: operand unpack, product or aligned sum
   logic [7:0]  ea, eb, ea_eff, eb_eff;
   logic [23:0] ma, mb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sa, sb;
   logic [47:0] prod;
   logic        a_big;
   logic [7:0]  big_e, small_e, shamt;
   logic [23:0] big_m, small_m;
   logic        big_s;
   logic [26:0] s27, sh27, al27, b27;
   logic        lost_al;
   logic [27:0] sum28;
   logic        f_sign, f_bypass;
   logic [31:0] f_bval;
   logic signed [10:0] f_exp;
   logic [47:0] f_man;

   always_comb begin
      ea = fpu_req.a[30:23];
      eb = fpu_req.b[30:23];
      sa = fpu_req.a[31];
      sb = fpu_req.b[31];
      ea_eff = (ea == 8'd0) ? 8'd1 : ea;
      eb_eff = (eb == 8'd0) ? 8'd1 : eb;
      ma = {ea != 8'd0, fpu_req.a[22:0]};
      mb = {eb != 8'd0, fpu_req.b[22:0]};
      a_nan  = (ea == 8'hFF) && (fpu_req.a[22:0] != 23'd0);
      b_nan  = (eb == 8'hFF) && (fpu_req.b[22:0] != 23'd0);
      a_inf  = (ea == 8'hFF) && (fpu_req.a[22:0] == 23'd0);
      b_inf  = (eb == 8'hFF) && (fpu_req.b[22:0] == 23'd0);
      a_zero = fpu_req.a[30:0] == 31'd0;
      b_zero = fpu_req.b[30:0] == 31'd0;

      prod = ma * mb;

      a_big   = fpu_req.a[30:0] >= fpu_req.b[30:0];
      big_e   = a_big ? ea_eff : eb_eff;
      small_e = a_big ? eb_eff : ea_eff;
      big_m   = a_big ? ma : mb;
      small_m = a_big ? mb : ma;
      big_s   = a_big ? sa : sb;
      shamt   = big_e - small_e;
      s27     = {small_m, 3'b000};
      sh27    = s27 >> shamt;
      lost_al = (sh27 << shamt) != s27;
      al27    = sh27 | {26'd0, lost_al};
      b27     = {big_m, 3'b000};
      sum28   = (sa == sb) ? ({1'b0, b27} + {1'b0, al27}) : ({1'b0, b27} - {1'b0, al27});

      f_bypass = 1'b0;
      f_bval   = 32'd0;
      if (fpu_req.op == FPU_MUL) begin
         f_sign = sa ^ sb;
         f_exp  = $signed(11'(ea_eff) + 11'(eb_eff) - 11'd126);
         f_man  = prod;
         if (a_nan) begin
            f_bypass = 1'b1;
            f_bval   = fpu_req.a | FP_QUIET_BIT;
         end else if (b_nan) begin
            f_bypass = 1'b1;
            f_bval   = fpu_req.b | FP_QUIET_BIT;
         end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            f_bypass = 1'b1;
            f_bval   = FP_DEFAULT_NAN;
         end else if (a_inf || b_inf) begin
            f_bypass = 1'b1;
            f_bval   = {sa ^ sb, 8'hFF, 23'd0};
         end else if (prod == 48'd0) begin
            f_bypass = 1'b1;
            f_bval   = {sa ^ sb, 31'd0};
         end
      end else begin
         f_sign = big_s;
         f_exp  = $signed(11'(big_e) + 11'd1);
         f_man  = {sum28, 20'd0};
         if (a_nan) begin
            f_bypass = 1'b1;
            f_bval   = fpu_req.a | FP_QUIET_BIT;
         end else if (b_nan) begin
            f_bypass = 1'b1;
            f_bval   = fpu_req.b | FP_QUIET_BIT;
         end else if (a_inf && b_inf && (sa != sb)) begin
            f_bypass = 1'b1;
            f_bval   = FP_DEFAULT_NAN;
         end else if (a_inf) begin
            f_bypass = 1'b1;
            f_bval   = fpu_req.a;
         end else if (b_inf) begin
            f_bypass = 1'b1;
            f_bval   = fpu_req.b;
         end else if (sum28 == 28'd0) begin
            // exact cancellation rounds to +0; two zeros keep a common sign
            f_bypass = 1'b1;
            f_bval   = {sa & sb, 31'd0};
         end
      end
   end

   // normalize, then denormalize when the exponent falls below the normal range
   logic [47:0]        mn, mdn;
   logic signed [10:0] en, shs;
   logic [6:0]         sh;
   logic               lost_dn;
   logic [7:0]         a_expf;
   logic               a_ovf;

   always_comb begin
      mn      = man_ff << lz_ff;
      en      = exp_ff - $signed({5'd0, lz_ff});
      shs     = 11'sd1 - en;
      sh      = 7'd0;
      mdn     = mn;
      lost_dn = 1'b0;
      a_expf  = en[7:0];
      a_ovf   = en >= 11'sd255;
      if (en < 11'sd1) begin
         sh      = (shs > 11'sd49) ? 7'd49 : shs[6:0];
         mdn     = mn >> sh;
         lost_dn = (mdn << sh) != mn;
         a_expf  = 8'd0;
      end
   end

   logic        inc;
   logic [30:0] packed_sum;

   always_comb begin
      inc        = guard_ff & (sticky_ff | frac_ff[0]);
      packed_sum = {expf_ff, frac_ff} + 31'(inc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            F_IDLE: begin
               if (fpu_req.start) begin
                  sign_ff   <= f_sign;
                  exp_ff    <= f_exp;
                  man_ff    <= f_man;
                  bypass_ff <= f_bypass;
                  bval_ff   <= f_bval;
                  state_ff  <= F_LZC;
               end
            end
            F_LZC: begin
               lz_ff    <= lead_zeros48(man_ff);
               state_ff <= F_ALIGN;
            end
            F_ALIGN: begin
               expf_ff   <= a_expf;
               frac_ff   <= mdn[46:24];
               guard_ff  <= mdn[23];
               sticky_ff <= (|mdn[22:0]) | lost_dn;
               ovf_ff    <= a_ovf;
               state_ff  <= F_ROUND;
            end
            F_ROUND: begin
               if (bypass_ff) begin
                  result_ff <= bval_ff;
               end else if (ovf_ff) begin
                  result_ff <= {sign_ff, 8'hFF, 23'd0};
               end else begin
                  result_ff <= {sign_ff, packed_sum};
               end
               done_ff  <= 1'b1;
               state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign fpu_rsp.done   = done_ff;
   assign fpu_rsp.result = result_ff;

endmodule

`default_nettype wire

>>> rtl/core/matrix_tile_register_mac_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake   | Payload
// ---------+-----+-------------+---------------------------------------------------
// req_bus  | in  | valid/ready | func, dest_reg, src_a_reg, src_b_reg, row, col, elem_in
// rsp_bus  | out | valid/ready | elem_out, status
// csr_bus  | in  | valid/ready | addr (0 m_group, 1 n_group), wdata
//
// Element write goes to ST_RESP, element read via ST_RD, and zero group clears m*n*DIM*DIM
// words in ST_ZERO. Multiply accumulate steps ST_RA, ST_RB, ST_RC, ST_MUL, ST_MULW, ST_ADDW
// per product term (three single-port tile memory reads, then one multiply and one add on the
// shared FPU), m*n*DIM^3 terms in all. Synchronous reset clears the tile valid bits at once.
// A finished transaction waits in the response register; the next one is accepted meanwhile.

module matrix_tile_register_mac_unit #(
   parameter int DIM       = mtrm_pkg::DIM_DEFAULT,
   parameter int NUM_TILES = mtrm_pkg::NUM_TILES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mtrm_req_if.sink   req_bus,
   mtrm_rsp_if.source rsp_bus,
   mtrm_csr_if.sink   csr_bus
);
   import mtrm_pkg::*;

   localparam int TILE_WORDS = DIM * DIM;
   localparam int DEPTH      = NUM_TILES * TILE_WORDS;
   localparam int AW         = $clog2(DEPTH);
   localparam int IW         = $clog2(DIM);
   localparam int CW         = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_ZERO, ST_RA, ST_RB, ST_RC, ST_MUL, ST_MULW, ST_ADDW, ST_RESP
   } state_type;

   // word address of element (r, c) of a tile
   function automatic logic [AW-1:0] elem_addr(input int tile, input int r, input int c);
      int v;
      v = tile * TILE_WORDS + r * DIM + c;
      return v[AW-1:0];
   endfunction

   // tile row or column of a panel position
   function automatic int div_dim(input logic [POS_W-1:0] v);
      int res;
      res = 0;
      for (int q = 0; q < 16; q++) begin
         if (int'(v) >= q * DIM) res = q;
      end
      return res;
   endfunction

   // ---------------- configuration ----------------
   logic [GROUP_W-1:0] m_group_ff, n_group_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_group_ff <= GROUP_W'(1);
         n_group_ff <= GROUP_W'(1);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            CSR_M_GROUP: m_group_ff <= csr_bus.wdata;
            CSR_N_GROUP: n_group_ff <= csr_bus.wdata;
            default: ;
         endcase
      end
   end

   // ---------------- sequencer registers ----------------
   state_type          state_ff;
   logic [REG_W-1:0]   md_ff, ma_ff, mb_ff;
   logic [5:0]         count_ff, x_ff;
   logic [GROUP_W-1:0] xa_ff, xb_ff;
   logic [IW-1:0]      i_ff, j_ff, k_ff;
   logic [AW-1:0]      zaddr_ff;
   logic [CW-1:0]      zcnt_ff;
   logic [WORD_W-1:0]  op_a_ff, op_b_ff, acc_ff;
   logic [WORD_W-1:0]  res_ff;
   logic               stat_ff;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_elem_ff;
   logic               rsp_stat_ff;

   // ---------------- command decode ----------------
   logic          req_fire, slot_free;
   int            tr, tc, rr, cc, tile_i, count_i;
   logic          pos_ok, zero_ok, mac_ok;
   logic [AW-1:0] pos_addr, a_addr, b_addr, c_addr;

   assign req_bus.ready = state_ff == ST_IDLE;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      tr      = div_dim(req_bus.panel_row);
      tc      = div_dim(req_bus.panel_col);
      rr      = int'(req_bus.panel_row) - tr * DIM;
      cc      = int'(req_bus.panel_col) - tc * DIM;
      tile_i  = int'(req_bus.dest_reg) + tr * int'(n_group_ff) + tc;
      pos_ok  = (tr < int'(m_group_ff)) && (tc < int'(n_group_ff)) && (tile_i < NUM_TILES);
      pos_addr = elem_addr(tile_i, rr, cc);
      count_i = int'(m_group_ff) * int'(n_group_ff);
      zero_ok = int'(req_bus.dest_reg) + count_i - 1 < NUM_TILES;
      mac_ok  = zero_ok
             && (int'(req_bus.src_a_reg) + int'(m_group_ff) - 1 < NUM_TILES)
             && (int'(req_bus.src_b_reg) + int'(n_group_ff) - 1 < NUM_TILES);
      a_addr  = elem_addr(int'(ma_ff) + int'(xa_ff), int'(i_ff), int'(k_ff));
      b_addr  = elem_addr(int'(mb_ff) + int'(xb_ff), int'(k_ff), int'(j_ff));
      c_addr  = elem_addr(int'(md_ff) + int'(x_ff), int'(i_ff), int'(j_ff));
   end

   // ---------------- shared FPU ----------------
   fpu_req_type fpu_req;
   fpu_rsp_type fpu_rsp;

   always_comb begin
      fpu_req.start = (state_ff == ST_MUL) || (state_ff == ST_MULW && fpu_rsp.done);
      fpu_req.op    = (state_ff == ST_MUL) ? FPU_MUL : FPU_ADD;
      fpu_req.a     = (state_ff == ST_MUL) ? op_a_ff : acc_ff;
      fpu_req.b     = (state_ff == ST_MUL) ? op_b_ff : fpu_rsp.result;
   end

   mtrm_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   // ---------------- tile memory ----------------
   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, mem_q;

   always_comb begin
      mem_we = (state_ff == ST_ZERO) || (state_ff == ST_ADDW && fpu_rsp.done)
            || (req_fire && func_type'(req_bus.func) == FUNC_WRITE && pos_ok);
      unique case (state_ff)
         ST_ZERO: begin
            mem_waddr = zaddr_ff;
            mem_wdata = '0;
         end
         ST_ADDW: begin
            mem_waddr = c_addr;
            mem_wdata = fpu_rsp.result;
         end
         default: begin
            mem_waddr = pos_addr;
            mem_wdata = req_bus.elem_in;
         end
      endcase
      unique case (state_ff)
         ST_RA:   mem_raddr = a_addr;
         ST_RB:   mem_raddr = b_addr;
         ST_RC:   mem_raddr = c_addr;
         default: mem_raddr = pos_addr;
      endcase
      mem_q = rd_vld_ff ? rd_data_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem_ff[mem_raddr];
   end

   // an entry never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) vld_ff[mem_waddr] <= 1'b1;
         rd_vld_ff <= vld_ff[mem_raddr];
      end
   end

   // ---------------- sequencer ----------------
   logic last_k, last_j, last_i, last_x;

   always_comb begin
      last_k = k_ff == IW'(DIM - 1);
      last_j = j_ff == IW'(DIM - 1);
      last_i = i_ff == IW'(DIM - 1);
      last_x = x_ff == count_ff - 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  md_ff    <= req_bus.dest_reg;
                  ma_ff    <= req_bus.src_a_reg;
                  mb_ff    <= req_bus.src_b_reg;
                  count_ff <= 6'(count_i);
                  res_ff   <= '0;
                  stat_ff  <= 1'b0;
                  state_ff <= ST_RESP;
                  unique case (func_type'(req_bus.func))
                     FUNC_WRITE: stat_ff <= !pos_ok;
                     FUNC_READ: begin
                        // read is already issued this cycle
                        if (pos_ok) state_ff <= ST_RD;
                        else stat_ff <= 1'b1;
                     end
                     FUNC_ZERO: begin
                        if (count_i != 0) begin
                           if (!zero_ok) begin
                              stat_ff <= 1'b1;
                           end else begin
                              zaddr_ff <= elem_addr(int'(req_bus.dest_reg), 0, 0);
                              zcnt_ff  <= CW'(count_i * TILE_WORDS);
                              state_ff <= ST_ZERO;
                           end
                        end
                     end
                     FUNC_MAC: begin
                        if (count_i != 0) begin
                           if (!mac_ok) begin
                              stat_ff <= 1'b1;
                           end else begin
                              x_ff     <= '0;
                              xa_ff    <= '0;
                              xb_ff    <= '0;
                              i_ff     <= '0;
                              j_ff     <= '0;
                              k_ff     <= '0;
                              state_ff <= ST_RA;
                           end
                        end
                     end
                     default: stat_ff <= 1'b1;
                  endcase
               end
            end
            ST_RD: begin
               res_ff   <= mem_q;
               state_ff <= ST_RESP;
            end
            ST_ZERO: begin
               zaddr_ff <= zaddr_ff + AW'(1);
               zcnt_ff  <= zcnt_ff - CW'(1);
               if (zcnt_ff == CW'(1)) state_ff <= ST_RESP;
            end
            ST_RA: state_ff <= ST_RB;
            ST_RB: begin
               op_a_ff  <= mem_q;
               state_ff <= ST_RC;
            end
            ST_RC: begin
               op_b_ff  <= mem_q;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               acc_ff   <= mem_q;
               state_ff <= ST_MULW;
            end
            ST_MULW: begin
               if (fpu_rsp.done) state_ff <= ST_ADDW;
            end
            ST_ADDW: begin
               if (fpu_rsp.done) begin
                  // advance k, then j, then i, then the tile of the group
                  state_ff <= ST_RA;
                  k_ff <= last_k ? '0 : k_ff + IW'(1);
                  if (last_k) begin
                     j_ff <= last_j ? '0 : j_ff + IW'(1);
                     if (last_j) begin
                        i_ff <= last_i ? '0 : i_ff + IW'(1);
                        if (last_i) begin
                           if (last_x) begin
                              state_ff <= ST_RESP;
                           end else begin
                              x_ff <= x_ff + 6'd1;
                              if (xb_ff == n_group_ff - GROUP_W'(1)) begin
                                 xb_ff <= '0;
                                 xa_ff <= xa_ff + GROUP_W'(1);
                              end else begin
                                 xb_ff <= xb_ff + GROUP_W'(1);
                              end
                           end
                        end
                     end
                  end
               end
            end
            ST_RESP: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_elem_ff  <= res_ff;
                  rsp_stat_ff  <= stat_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.elem_out = rsp_elem_ff;
   assign rsp_bus.status   = rsp_stat_ff;

`ifndef NO_ASSERTIONS
   // error responses never carry data
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff |-> rsp_elem_ff == '0)
      else $error("error response carries element data");

   // FPU results arrive only while the sequencer waits for them
   a_fpu_done_wait: assert property (@(posedge clock) disable iff (reset)
      fpu_rsp.done |-> (state_ff == ST_MULW || state_ff == ST_ADDW))
      else $error("FPU result outside a wait state");

   // the zero sweep never runs past its word count
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ZERO |-> zcnt_ff != '0)
      else $error("zero sweep word count underflow");
`endif

endmodule

`default_nettype wire
